@@ hw/rtl/txrpf_pkg.sv @@
// Package: shared types, constants and codes of the transmit rate and power fallback unit.
`timescale 1ns / 1ps

package txrpf_pkg;

  localparam int unsigned STATIONS = 64;
  localparam int unsigned ADDR_W   = (STATIONS > 1) ? $clog2(STATIONS) : 1;

  localparam logic [1:0] FUNC_INIT  = 2'd0;
  localparam logic [1:0] FUNC_OK    = 2'd1;
  localparam logic [1:0] FUNC_FAIL  = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  localparam logic [1:0] CFG_SUCCESS_THR = 2'd0;
  localparam logic [1:0] CFG_TIMER_THR   = 2'd1;
  localparam logic [1:0] CFG_POWER_LVLS  = 2'd2;
  localparam logic [1:0] CFG_RATE_COUNT  = 2'd3;

  localparam logic [15:0] SUCCESS_THR_RST = 16'd10;
  localparam logic [15:0] TIMER_THR_RST   = 16'd15;
  localparam logic [8:0]  POWER_LVLS_RST  = 9'd16;
  localparam logic [6:0]  RATE_COUNT_RST  = 7'd8;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] station;
  } in_t;

  typedef struct packed {
    logic [5:0] rate_index;
    logic [7:0] power_level;
    logic       rate_changed;
    logic       power_changed;
  } out_t;

  typedef struct packed {
    logic [31:0] timer_count;
    logic [15:0] success_count;
    logic [31:0] retry_count;
    logic        rate_recovery;
    logic        power_recovery;
    logic [5:0]  rate_now;
    logic [7:0]  power_now;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [15:0] success_threshold;
    logic [15:0] timer_threshold;
    logic [8:0]  power_levels;
    logic [6:0]  rate_count;
  } cfg_t;

endpackage

@@ hw/rtl/tx_rate_power_fallback_unit.sv @@
// Top level: per-station transmit rate and power fallback controller.
// The command and the station entry read for it are registered when the command is
// taken; the updated result and its strobe are registered from the busy state.
// Commands do not overlap: busy holds off a new command while the read-modify-write
// of the station memory (registered read, then update and write back) completes.
// Reset: configuration registers take their defaults; the station memory is not
// cleared, and a station must see an init event before other events.
`timescale 1ns / 1ps

module tx_rate_power_fallback_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  txrpf_pkg::in_t    in_data,
  output logic              out_valid,
  output txrpf_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import txrpf_pkg::*;

  state_t             state_r, state_nxt;
  cfg_t               cfg_r;
  logic [1:0]         func_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               in_range_r;
  logic               out_valid_r;
  out_t               out_data_r;
  out_t               out_data_nxt;

  logic               accept;
  logic               in_range;
  logic               wr_en;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             entry_rd;
  entry_t             entry_wr;
  out_t               upd_result;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_range  = 32'(in_data.station) < STATIONS;
  assign entry_rd  = entry_t'(rd_data);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_BUSY;
      ST_BUSY: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b0;
    wr_en = 1'b0;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_BUSY: begin
        busy  = 1'b1;
        wr_en = in_range_r;
      end
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    out_data_nxt = in_range_r ? upd_result : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_r.success_threshold <= SUCCESS_THR_RST;
      cfg_r.timer_threshold   <= TIMER_THR_RST;
      cfg_r.power_levels      <= POWER_LVLS_RST;
      cfg_r.rate_count        <= RATE_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_BUSY);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SUCCESS_THR: cfg_r.success_threshold <= cfg_data;
          CFG_TIMER_THR:   cfg_r.timer_threshold   <= cfg_data;
          CFG_POWER_LVLS:  cfg_r.power_levels      <= cfg_data[8:0];
          CFG_RATE_COUNT:  cfg_r.rate_count        <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_data.func;
      addr_r     <= ADDR_W'(in_data.station);
      in_range_r <= in_range;
    end
    if (state_r == ST_BUSY) begin
      out_data_r <= out_data_nxt;
    end
  end

  txrpf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STATIONS),
    .AW    (ADDR_W)
  ) u_station_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (entry_wr),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(in_data.station)),
    .rd_data (rd_data)
  );

  txrpf_update u_update (
    .func      (func_r),
    .cfg       (cfg_r),
    .entry_in  (entry_rd),
    .entry_out (entry_wr),
    .result    (upd_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/txrpf_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module txrpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/txrpf_update.sv @@
// Station entry update: applies one event to a station entry and forms the result.
`timescale 1ns / 1ps

module txrpf_update (
  input  logic [1:0]      func,
  input  txrpf_pkg::cfg_t cfg,
  input  txrpf_pkg::entry_t entry_in,
  output txrpf_pkg::entry_t entry_out,
  output txrpf_pkg::out_t result
);
  import txrpf_pkg::*;

  logic [7:0]  max_pwr;
  logic [5:0]  top_rate;
  logic [31:0] timer_inc;
  logic [31:0] retry_inc;
  logic [15:0] succ_inc;
  logic        hit;
  logic        rc;
  logic        pc;
  entry_t      e;

  always_comb begin
    max_pwr = cfg.power_levels[7:0] - 8'd1;
    if (cfg.rate_count == 7'd0) begin
      top_rate = 6'd0;
    end else if (cfg.rate_count > 7'd64) begin
      top_rate = 6'd63;
    end else begin
      top_rate = 6'(cfg.rate_count - 7'd1);
    end
  end

  always_comb begin
    e         = entry_in;
    rc        = 1'b0;
    pc        = 1'b0;
    timer_inc = entry_in.timer_count + 32'd1;
    retry_inc = entry_in.retry_count + 32'd1;
    succ_inc  = entry_in.success_count + 16'd1;
    hit       = (succ_inc == cfg.success_threshold) ||
                (timer_inc == {16'd0, cfg.timer_threshold});
    case (func)
      FUNC_INIT: begin
        e.timer_count    = '0;
        e.success_count  = '0;
        e.retry_count    = '0;
        e.rate_recovery  = 1'b0;
        e.power_recovery = 1'b0;
        e.rate_now       = '0;
        e.power_now      = max_pwr;
        rc = 1'b1;
        pc = 1'b1;
      end
      FUNC_OK: begin
        e.timer_count    = timer_inc;
        e.success_count  = succ_inc;
        e.rate_recovery  = 1'b0;
        e.power_recovery = 1'b0;
        e.retry_count    = '0;
        if (hit) begin
          if (entry_in.rate_now < top_rate) begin
            e.rate_now      = entry_in.rate_now + 6'd1;
            rc              = 1'b1;
            e.rate_recovery = 1'b1;
          end else begin
            if (entry_in.power_now != 8'd0) begin
              e.power_now = entry_in.power_now - 8'd1;
              pc          = 1'b1;
            end
            e.power_recovery = 1'b1;
          end
          e.timer_count   = '0;
          e.success_count = '0;
        end
      end
      FUNC_FAIL: begin
        e.timer_count   = timer_inc;
        e.retry_count   = retry_inc;
        e.success_count = '0;
        if (entry_in.rate_recovery) begin
          if (retry_inc == 32'd1 && entry_in.rate_now != 6'd0) begin
            e.rate_now      = entry_in.rate_now - 6'd1;
            rc              = 1'b1;
            e.rate_recovery = 1'b0;
          end
          e.timer_count = '0;
        end else if (entry_in.power_recovery) begin
          if (retry_inc == 32'd1 && entry_in.power_now < max_pwr) begin
            e.power_now      = entry_in.power_now + 8'd1;
            pc               = 1'b1;
            e.power_recovery = 1'b0;
          end
          e.timer_count = '0;
        end else begin
          if (!retry_inc[0]) begin
            if (entry_in.power_now == max_pwr) begin
              if (entry_in.rate_now != 6'd0) begin
                e.rate_now = entry_in.rate_now - 6'd1;
                rc         = 1'b1;
              end
            end else begin
              e.power_now = entry_in.power_now + 8'd1;
              pc          = 1'b1;
            end
          end
          if (retry_inc >= 32'd2) begin
            e.timer_count = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign entry_out            = e;
  assign result.rate_index    = e.rate_now;
  assign result.power_level   = e.power_now;
  assign result.rate_changed  = rc;
  assign result.power_changed = pc;

endmodule

@@ bench/tb_top.sv @@
// Testbench for the per-station transmit rate and power fallback unit.
`timescale 1ns / 1ps

module tb_top;
  import txrpf_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  in_t         in_data   = '0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_SUCCESS_THR;
  logic [15:0] cfg_data  = '0;
  logic        busy;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_ready;

  tx_rate_power_fallback_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow registers and per-station entries
  logic [15:0] thr_success = SUCCESS_THR_RST;
  logic [15:0] thr_timer   = TIMER_THR_RST;
  logic [8:0]  n_power     = POWER_LVLS_RST;
  logic [6:0]  n_rate      = RATE_COUNT_RST;

  bit [31:0] ev_timer [STATIONS];
  bit [15:0] ok_run   [STATIONS];
  bit [31:0] fail_run [STATIONS];
  bit        rate_rec [STATIONS];
  bit        pwr_rec  [STATIONS];
  bit [5:0]  rate_cur [STATIONS];
  bit [7:0]  pwr_cur  [STATIONS];
  bit        live_sta [STATIONS];

  in_t  pending_cmds[$];
  out_t expected_results[$];
  int   mismatches = 0;
  int   burst_left = 1;
  int   gap_left   = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 50)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic out_t predict_event(input in_t cmd);
    logic [5:0]  s;
    logic [7:0]  pmax;
    logic [5:0]  rtop;
    logic        rc;
    logic        pc;
    logic        hit;
    out_t        res;
    s    = cmd.station;
    pmax = 8'(n_power - 9'd1);
    rtop = (n_rate == 7'd0) ? 6'd0 : (n_rate > 7'd64) ? 6'd63 : 6'(n_rate - 7'd1);
    rc   = 1'b0;
    pc   = 1'b0;
    case (cmd.func)
      FUNC_INIT: begin
        ev_timer[s] = '0;
        ok_run[s]   = '0;
        fail_run[s] = '0;
        rate_rec[s] = 1'b0;
        pwr_rec[s]  = 1'b0;
        rate_cur[s] = '0;
        pwr_cur[s]  = pmax;
        rc = 1'b1;
        pc = 1'b1;
      end
      FUNC_OK: begin
        ev_timer[s] = ev_timer[s] + 32'd1;
        ok_run[s]   = ok_run[s] + 16'd1;
        rate_rec[s] = 1'b0;
        pwr_rec[s]  = 1'b0;
        fail_run[s] = '0;
        hit = (ok_run[s] == thr_success) || (ev_timer[s] == {16'd0, thr_timer});
        if (hit) begin
          if (rate_cur[s] < rtop) begin
            rate_cur[s] = rate_cur[s] + 6'd1;
            rc = 1'b1;
            rate_rec[s] = 1'b1;
          end else begin
            if (pwr_cur[s] != 8'd0) begin
              pwr_cur[s] = pwr_cur[s] - 8'd1;
              pc = 1'b1;
            end
            pwr_rec[s] = 1'b1;
          end
          ev_timer[s] = '0;
          ok_run[s]   = '0;
        end
      end
      FUNC_FAIL: begin
        ev_timer[s] = ev_timer[s] + 32'd1;
        fail_run[s] = fail_run[s] + 32'd1;
        ok_run[s]   = '0;
        if (rate_rec[s]) begin
          if (fail_run[s] == 32'd1 && rate_cur[s] != 6'd0) begin
            rate_cur[s] = rate_cur[s] - 6'd1;
            rc = 1'b1;
            rate_rec[s] = 1'b0;
          end
          ev_timer[s] = '0;
        end else if (pwr_rec[s]) begin
          if (fail_run[s] == 32'd1 && pwr_cur[s] < pmax) begin
            pwr_cur[s] = pwr_cur[s] + 8'd1;
            pc = 1'b1;
            pwr_rec[s] = 1'b0;
          end
          ev_timer[s] = '0;
        end else begin
          if (!fail_run[s][0]) begin
            if (pwr_cur[s] == pmax) begin
              if (rate_cur[s] != 6'd0) begin
                rate_cur[s] = rate_cur[s] - 6'd1;
                rc = 1'b1;
              end
            end else begin
              pwr_cur[s] = pwr_cur[s] + 8'd1;
              pc = 1'b1;
            end
          end
          if (fail_run[s] >= 32'd2)
            ev_timer[s] = '0;
        end
      end
      default: ;
    endcase
    res.rate_index    = rate_cur[s];
    res.power_level   = pwr_cur[s];
    res.rate_changed  = rc;
    res.power_changed = pc;
    return res;
  endfunction

  // Command driver: bursts with random gaps, hold start until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy)
        expected_results.push_back(predict_event(in_data));
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          start   <= 1'b1;
          in_data <= pending_cmds.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_mon
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, rate_index", int'(out_data.rate_index), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.rate_index != want.rate_index)
          report_mismatch("rate_index", int'(out_data.rate_index),
                          int'(want.rate_index));
        if (out_data.power_level != want.power_level)
          report_mismatch("power_level", int'(out_data.power_level),
                          int'(want.power_level));
        if (out_data.rate_changed != want.rate_changed)
          report_mismatch("rate_changed", int'(out_data.rate_changed),
                          int'(want.rate_changed));
        if (out_data.power_changed != want.power_changed)
          report_mismatch("power_changed", int'(out_data.power_changed),
                          int'(want.power_changed));
      end
    end
  end

  function automatic void queue_cmd(input logic [1:0] f, input int s);
    in_t c;
    c.func    = f;
    c.station = 6'(s);
    if (f == FUNC_INIT)
      live_sta[6'(s)] = 1'b1;
    pending_cmds.push_back(c);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SUCCESS_THR: thr_success = val;
      CFG_TIMER_THR:   thr_timer   = val;
      CFG_POWER_LVLS:  n_power     = val[8:0];
      CFG_RATE_COUNT:  n_rate      = val[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] sthr, input logic [15:0] tthr,
                          input logic [15:0] plev, input logic [15:0] rcnt);
    write_reg(CFG_SUCCESS_THR, sthr);
    write_reg(CFG_TIMER_THR, tthr);
    write_reg(CFG_POWER_LVLS, plev);
    write_reg(CFG_RATE_COUNT, rcnt);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic gen_traffic(input int n);
    int made;
    int s;
    int run;
    int pick;
    made = 0;
    while (made < n) begin
      s    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 63);
      pick = $urandom_range(0, 99);
      if (!live_sta[6'(s)] || pick >= 95) begin
        queue_cmd(FUNC_INIT, s);
        made++;
      end else if (pick < 50) begin
        run = $urandom_range(1, 12);
        repeat (run) queue_cmd(FUNC_OK, s);
        made += run;
      end else if (pick < 80) begin
        run = $urandom_range(1, 4);
        repeat (run) queue_cmd(FUNC_FAIL, s);
        made += run;
      end else if (pick < 86) begin
        queue_cmd(FUNC_QUERY, s);
        made++;
      end else begin
        run = $urandom_range(1, 6);
        repeat (run) queue_cmd(2'($urandom_range(1, 3)), s);
        made += run;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    queue_cmd(FUNC_INIT, 0);
    queue_cmd(FUNC_INIT, 63);
    queue_cmd(FUNC_QUERY, 0);
    queue_cmd(FUNC_QUERY, 63);
    queue_cmd(FUNC_OK, 63);
    queue_cmd(FUNC_FAIL, 63);
    queue_cmd(FUNC_FAIL, 63);
    repeat (10) queue_cmd(FUNC_OK, 0);
    queue_cmd(FUNC_FAIL, 0);
    queue_cmd(FUNC_OK, 0);
    queue_cmd(FUNC_FAIL, 0);
    queue_cmd(FUNC_FAIL, 0);
    queue_cmd(FUNC_INIT, 63);
    drain();

    gen_traffic(70);
    drain();
    set_regs(16'd1, 16'd1, 16'd1, 16'd1);
    gen_traffic(70);
    drain();
    set_regs(16'd2, 16'd3, 16'd4, 16'd4);
    gen_traffic(80);
    drain();
    set_regs(16'd65535, 16'd65535, 16'd256, 16'd64);
    gen_traffic(70);
    drain();
    set_regs(16'd3, 16'd0, 16'd0, 16'd0);
    gen_traffic(70);
    drain();
    set_regs(16'd4, 16'd2, 16'd511, 16'd127);
    gen_traffic(70);
    drain();
    set_regs(16'd5, 16'd7, 16'd300, 16'd100);
    gen_traffic(70);
    drain();
    set_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 12)),
             16'($urandom_range(1, 16)), 16'($urandom_range(1, 10)));
    gen_traffic(80);
    drain();

    if (mismatches == 0)
      $display("[tx_rate_power_fallback_unit] OK");
    else
      $display("[tx_rate_power_fallback_unit] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[tx_rate_power_fallback_unit] ERROR");
    $finish;
  end

endmodule

@@ tx_rate_power_fallback_unit.f @@
hw/rtl/txrpf_pkg.sv
hw/rtl/txrpf_ram.sv
hw/rtl/txrpf_update.sv
hw/rtl/tx_rate_power_fallback_unit.sv
bench/tb_top.sv
